FILE: hw/rtl/rci_pkg.sv
// Shared types and constants for the ray/circle intersection pipeline.
// Used by the top level and by the square-root and divider pipelines.
// No dependencies.
`default_nettype none

package rci_pkg;

  // Pipeline step control shared by every stage: global advance and stage valid.
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_CENTER_X = 2'd1,
    CFG_CENTER_Y = 2'd2
  } cfg_idx_e;

  localparam logic signed [31:0] DP_MAX = 32'sh7fff_ffff;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam int ROT_FRAC_BITS = 14;
  localparam int FRAC_W = 31;
  localparam int NORM_W = 16;
  localparam int NORM_QW = 15;

endpackage

`default_nettype wire

FILE: hw/rtl/rci_isqrt_pipe.sv
// Pipelined floor integer square root, one result bit per register stage.
// Carries a sideband vector alongside; uses rci_pkg::pipe_ctl_t.
`default_nettype none

module rci_isqrt_pipe #(
  parameter int RAD_W  = 128,
  parameter int SIDE_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rci_pkg::pipe_ctl_t      ctl_i,
  input  logic [RAD_W-1:0]        rad_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    vld_o,
  output logic [RAD_W/2-1:0]      root_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int ROOT_W = RAD_W / 2;

  logic                vld_q  [ROOT_W];
  logic [RAD_W-1:0]    rad_q  [ROOT_W];
  logic [ROOT_W:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [SIDE_W-1:0]   side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic                vld_p;
    logic [RAD_W-1:0]    rad_p;
    logic [ROOT_W:0]     rem_p;
    logic [ROOT_W-1:0]   root_p;
    logic [SIDE_W-1:0]   side_p;
    logic [ROOT_W+2:0]   rem_sh;
    logic [ROOT_W+2:0]   trial;
    logic                ge;
    logic [RAD_W-1:0]    rad_d;
    logic [ROOT_W:0]     rem_d;
    logic [ROOT_W-1:0]   root_d;

    if (k == 0) begin : g_first
      assign vld_p  = ctl_i.vld;
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
    end

    // Bring down the next two radicand bits and try 4*root + 1.
    always_comb begin
      rem_sh = {rem_p, rad_p[RAD_W-1 -: 2]};
      trial  = {1'b0, root_p, 2'b01};
      ge     = (rem_sh >= trial);
      rem_d  = ge ? (ROOT_W+1)'(rem_sh - trial) : (ROOT_W+1)'(rem_sh);
      root_d = {root_p[ROOT_W-2:0], ge};
      rad_d  = rad_p << 2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rad_q[k]  <= rad_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/rci_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage, with
// several numerator lanes sharing one divisor. Uses rci_pkg::pipe_ctl_t.
`default_nettype none

module rci_div_pipe #(
  parameter int NUM_W  = 79,
  parameter int DEN_W  = 63,
  parameter int QW     = 31,
  parameter int LANES  = 1,
  parameter int SIDE_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rci_pkg::pipe_ctl_t   ctl_i,
  input  logic [NUM_W-1:0]     num_i [LANES],
  input  logic [DEN_W-1:0]     den_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output logic [QW-1:0]        quo_o [LANES],
  output logic [SIDE_W-1:0]    side_o
);

  // The caller guarantees num < den * 2^QW on every lane.
  localparam int CW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

  logic              vld_q  [QW];
  logic [DEN_W-1:0]  den_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];
  logic [NUM_W-1:0]  rem_q  [QW][LANES];
  logic [QW-1:0]     quo_q  [QW][LANES];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int SH = QW - 1 - k;

    logic              vld_p;
    logic [DEN_W-1:0]  den_p;
    logic [SIDE_W-1:0] side_p;
    logic [NUM_W-1:0]  rem_p [LANES];
    logic [QW-1:0]     quo_p [LANES];
    logic [CW-1:0]     dsh;
    logic [NUM_W-1:0]  rem_d [LANES];
    logic [QW-1:0]     quo_d [LANES];

    if (k == 0) begin : g_first
      assign vld_p  = ctl_i.vld;
      assign den_p  = den_i;
      assign side_p = side_i;
      assign rem_p  = num_i;
      assign quo_p  = '{default: '0};
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign den_p  = den_q[k-1];
      assign side_p = side_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign quo_p  = quo_q[k-1];
    end

    always_comb begin
      dsh = CW'(den_p) << SH;
      for (int l = 0; l < LANES; l++) begin
        rem_d[l] = (CW'(rem_p[l]) >= dsh) ? NUM_W'(CW'(rem_p[l]) - dsh) : rem_p[l];
        quo_d[l] = quo_p[l] | (QW'(CW'(rem_p[l]) >= dsh) << SH);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire

FILE: hw/rtl/ray_circle_intersect.sv
// Ray against circle: each accepted input transaction yields the matching result
// on the output; one transaction per cycle sustained while the output buffer is not full.
// The depth is set by the two bit-serial square-root pipelines and the two
// restoring divider pipelines; a two-entry output buffer lets the pipeline
// keep accepting while one result waits. Reset empties the pipeline and
// clears the radius and local centre registers to zero.
`default_nettype none

module ray_circle_intersect #(
  parameter int COORD_WIDTH     = 32,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rci_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COORD_WIDTH-1:0]                 cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]          ray_origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]          ray_origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]          ray_dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]          ray_dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]          pose_x_i,
  input  logic signed [COORD_WIDTH-1:0]          pose_y_i,
  input  logic signed [15:0]                     pose_cos_i,
  input  logic signed [15:0]                     pose_sin_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   hit_o,
  output logic [rci_pkg::FRAC_W-1:0]             hit_fraction_o,
  output logic signed [rci_pkg::NORM_W-1:0]      normal_x_o,
  output logic signed [rci_pkg::NORM_W-1:0]      normal_y_o
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = COORD_FRAC_BITS;
  localparam int NUM1_W = 63 + F;
  localparam int NUM2_W = 46;
  localparam logic signed [71:0] DPM72 = 72'(rci_pkg::DP_MAX);
  localparam logic signed [71:0] CMAX  = (72'sd1 <<< (W - 1)) - 72'sd1;
  localparam logic signed [71:0] CMIN  = -CMAX - 72'sd1;

  typedef struct packed {
    logic               miss;
    logic [62:0]        bm;
    logic [62:0]        a;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } sq1_side_t;

  typedef struct packed {
    logic               miss;
    logic               over;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } div1_side_t;

  typedef struct packed {
    logic        miss;
    logic [30:0] f;
    logic [30:0] mx;
    logic [30:0] my;
    logic        negx;
    logic        negy;
  } sq2_side_t;

  typedef struct packed {
    logic        miss;
    logic        lz;
    logic [30:0] f;
    logic        negx;
    logic        negy;
  } div2_side_t;

  typedef struct packed {
    logic                                hit;
    logic [rci_pkg::FRAC_W-1:0]          frac;
    logic signed [rci_pkg::NORM_W-1:0]   nx;
    logic signed [rci_pkg::NORM_W-1:0]   ny;
  } result_t;

  function automatic logic signed [31:0] sat_dp(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > DPM72) begin
      r = rci_pkg::DP_MAX;
    end else if (v < -DPM72) begin
      r = -rci_pkg::DP_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [71:0] v);
    logic signed [W-1:0] r;
    if (v > CMAX) begin
      r = CMAX[W-1:0];
    end else if (v < CMIN) begin
      r = CMIN[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_rot(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v > rci_pkg::ONE_Q14) begin
      r = rci_pkg::ONE_Q14;
    end else if (v < -rci_pkg::ONE_Q14) begin
      r = -rci_pkg::ONE_Q14;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [W-2:0]        radius_q;
  logic signed [W-1:0] cx_q;
  logic signed [W-1:0] cy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (rci_pkg::cfg_idx_e'(cfg_index_i))
        rci_pkg::CFG_RADIUS:   radius_q <= cfg_data_i[W-2:0];
        rci_pkg::CFG_CENTER_X: cx_q     <= cfg_data_i;
        rci_pkg::CFG_CENTER_Y: cy_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [71:0] r72;
  logic signed [31:0] r_dp;
  assign r72  = 72'($signed({1'b0, radius_q}));
  assign r_dp = (r72 > DPM72) ? rci_pkg::DP_MAX : r72[31:0];

  // ------------------------------------------------------- flow control
  logic    pipe_en;
  logic [1:0] cnt_q;
  assign pipe_en    = (cnt_q != 2'd2);
  assign in_ready_o = pipe_en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic v9_q, v10_q, v11_q, v12_q, v13_q, v14_q, v15_q;
  logic sq1_vld, dv1_vld, sq2_vld, dv2_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0; v2_q  <= 1'b0; v3_q  <= 1'b0; v4_q  <= 1'b0;
      v5_q  <= 1'b0; v6_q  <= 1'b0; v7_q  <= 1'b0; v8_q  <= 1'b0;
      v9_q  <= 1'b0; v10_q <= 1'b0; v11_q <= 1'b0; v12_q <= 1'b0;
      v13_q <= 1'b0; v14_q <= 1'b0; v15_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= sq1_vld;
      v10_q <= v9_q;
      v11_q <= dv1_vld;
      v12_q <= v11_q;
      v13_q <= v12_q;
      v14_q <= v13_q;
      v15_q <= sq2_vld;
    end
  end

  // ------------------------------------------- stage 1: rotation products
  logic signed [W-1:0]  ox1_q, oy1_q, px1_q, py1_q;
  logic signed [31:0]   dx1_q, dy1_q;
  logic signed [W+15:0] mxc1_q, mys1_q, mxs1_q, myc1_q;
  logic signed [15:0]   cs_d, sn_d;
  logic signed [31:0]   dx1_d, dy1_d;
  logic signed [W+15:0] mxc1_d, mys1_d, mxs1_d, myc1_d;

  always_comb begin
    cs_d   = sat_rot(pose_cos_i);
    sn_d   = sat_rot(pose_sin_i);
    dx1_d  = sat_dp(72'(ray_dir_x_i));
    dy1_d  = sat_dp(72'(ray_dir_y_i));
    mxc1_d = cx_q * cs_d;
    mys1_d = cy_q * sn_d;
    mxs1_d = cx_q * sn_d;
    myc1_d = cy_q * cs_d;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ox1_q  <= ray_origin_x_i;
      oy1_q  <= ray_origin_y_i;
      px1_q  <= pose_x_i;
      py1_q  <= pose_y_i;
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
      mxc1_q <= mxc1_d;
      mys1_q <= mys1_d;
      mxs1_q <= mxs1_d;
      myc1_q <= myc1_d;
    end
  end

  // --------------------------------------- stage 2: world centre, rounded
  logic signed [W-1:0] ox2_q, oy2_q, gx2_q, gy2_q;
  logic signed [31:0]  dx2_q, dy2_q;
  logic signed [71:0]  rotx_d, roty_d;
  logic signed [W-1:0] gx2_d, gy2_d;

  always_comb begin
    rotx_d = (72'(mxc1_q) - 72'(mys1_q) + (72'sd1 <<< (rci_pkg::ROT_FRAC_BITS - 1)))
             >>> rci_pkg::ROT_FRAC_BITS;
    roty_d = (72'(mxs1_q) + 72'(myc1_q) + (72'sd1 <<< (rci_pkg::ROT_FRAC_BITS - 1)))
             >>> rci_pkg::ROT_FRAC_BITS;
    gx2_d  = sat_w(72'(px1_q) + rotx_d);
    gy2_d  = sat_w(72'(py1_q) + roty_d);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ox2_q <= ox1_q;
      oy2_q <= oy1_q;
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      gx2_q <= gx2_d;
      gy2_q <= gy2_d;
    end
  end

  // ------------------------------------------ stage 3: origin minus centre
  logic signed [31:0] sx3_q, sy3_q, dx3_q, dy3_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sx3_q <= sat_dp(72'(ox2_q) - 72'(gx2_q));
      sy3_q <= sat_dp(72'(oy2_q) - 72'(gy2_q));
      dx3_q <= dx2_q;
      dy3_q <= dy2_q;
    end
  end

  // ------------------------------------------------ stage 4: dot products
  logic signed [63:0] dxx4_q, dyy4_q, sxx4_q, syy4_q, sxd4_q, syd4_q, rr4_q;
  logic signed [31:0] sx4_q, sy4_q, dx4_q, dy4_q;
  logic signed [63:0] dxx4_d, dyy4_d, sxx4_d, syy4_d, sxd4_d, syd4_d, rr4_d;

  always_comb begin
    dxx4_d = dx3_q * dx3_q;
    dyy4_d = dy3_q * dy3_q;
    sxx4_d = sx3_q * sx3_q;
    syy4_d = sy3_q * sy3_q;
    sxd4_d = sx3_q * dx3_q;
    syd4_d = sy3_q * dy3_q;
    rr4_d  = r_dp * r_dp;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dxx4_q <= dxx4_d;
      dyy4_q <= dyy4_d;
      sxx4_q <= sxx4_d;
      syy4_q <= syy4_d;
      sxd4_q <= sxd4_d;
      syd4_q <= syd4_d;
      rr4_q  <= rr4_d;
      sx4_q  <= sx3_q;
      sy4_q  <= sy3_q;
      dx4_q  <= dx3_q;
      dy4_q  <= dy3_q;
    end
  end

  // ------------------------------------- stage 5: A, B, C and early misses
  sq1_side_t          s5_d, s5_q;
  logic [62:0]        c5_d, c5_q;
  logic signed [63:0] a_d, ss_d, b_d, nb_d;

  always_comb begin
    a_d     = dxx4_q + dyy4_q;
    ss_d    = sxx4_q + syy4_q;
    b_d     = sxd4_q + syd4_q;
    nb_d    = -b_d;
    c5_d    = 63'(ss_d - rr4_q);
    s5_d.miss = (a_d == 64'sd0) || (ss_d < rr4_q) || (b_d > 64'sd0);
    s5_d.bm = nb_d[62:0];
    s5_d.a  = a_d[62:0];
    s5_d.dx = dx4_q;
    s5_d.dy = dy4_q;
    s5_d.sx = sx4_q;
    s5_d.sy = sy4_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s5_q <= s5_d;
      c5_q <= c5_d;
    end
  end

  // ---------------------------- stage 6: partial products of B*B and A*C
  sq1_side_t   s6_q;
  logic [63:0] bhh6_q, bhl6_q, bll6_q, ahh6_q, ahl6_q, alh6_q, all6_q;
  logic [63:0] bhh6_d, bhl6_d, bll6_d, ahh6_d, ahl6_d, alh6_d, all6_d;

  always_comb begin
    bhh6_d = s5_q.bm[62:32] * s5_q.bm[62:32];
    bhl6_d = s5_q.bm[62:32] * s5_q.bm[31:0];
    bll6_d = s5_q.bm[31:0]  * s5_q.bm[31:0];
    ahh6_d = s5_q.a[62:32]  * c5_q[62:32];
    ahl6_d = s5_q.a[62:32]  * c5_q[31:0];
    alh6_d = s5_q.a[31:0]   * c5_q[62:32];
    all6_d = s5_q.a[31:0]   * c5_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s6_q   <= s5_q;
      bhh6_q <= bhh6_d;
      bhl6_q <= bhl6_d;
      bll6_q <= bll6_d;
      ahh6_q <= ahh6_d;
      ahl6_q <= ahl6_d;
      alh6_q <= alh6_d;
      all6_q <= all6_d;
    end
  end

  // --------------------------------------- stage 7: sum partial products
  sq1_side_t    s7_q;
  logic [127:0] b2_7_q, ac7_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s7_q   <= s6_q;
      // The cross term of B*B appears twice, hence the extra shift.
      b2_7_q <= (128'(bhh6_q) << 64) + (128'(bhl6_q) << 33) + 128'(bll6_q);
      ac7_q  <= (128'(ahh6_q) << 64) + (128'(ahl6_q) << 32) + (128'(alh6_q) << 32)
                + 128'(all6_q);
    end
  end

  // ------------------------------------------------ stage 8: discriminant
  sq1_side_t    s8_d, s8_q;
  logic [127:0] d8_q;

  always_comb begin
    s8_d      = s7_q;
    s8_d.miss = s7_q.miss || (b2_7_q < ac7_q);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s8_q <= s8_d;
      d8_q <= b2_7_q - ac7_q;
    end
  end

  // -------------------------------------------------- square root of D
  rci_pkg::pipe_ctl_t sq1_ctl;
  logic [63:0]        sq1_root;
  sq1_side_t          sq1_so;

  assign sq1_ctl = '{en: pipe_en, vld: v8_q};

  rci_isqrt_pipe #(
    .RAD_W  (128),
    .SIDE_W ($bits(sq1_side_t))
  ) u_sqrt_disc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq1_ctl),
    .rad_i  (d8_q),
    .side_i (s8_q),
    .vld_o  (sq1_vld),
    .root_o (sq1_root),
    .side_o (sq1_so)
  );

  // stage 9: numerator term, minus B minus the root of D
  sq1_side_t   s9_q;
  logic [62:0] tn9_q;
  logic [63:0] tn9_d;

  assign tn9_d = {1'b0, sq1_so.bm} - sq1_root;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s9_q  <= sq1_so;
      tn9_q <= tn9_d[62:0];
    end
  end

  // ------------------------------------------ stage 10: overflow check
  div1_side_t        side10_d, side10_q;
  logic [NUM1_W-1:0] num10_d, num10_q;
  logic [62:0]       den10_q;
  logic [NUM1_W-1:0] num_full;
  logic [93:0]       a_sh;

  always_comb begin
    num_full      = {tn9_q, {F{1'b0}}};
    a_sh          = {s9_q.a, 31'b0};
    side10_d.miss = s9_q.miss;
    side10_d.over = (num_full >= a_sh);
    side10_d.dx   = s9_q.dx;
    side10_d.dy   = s9_q.dy;
    side10_d.sx   = s9_q.sx;
    side10_d.sy   = s9_q.sy;
    num10_d       = side10_d.over ? '0 : num_full;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side10_q <= side10_d;
      num10_q  <= num10_d;
      den10_q  <= s9_q.a;
    end
  end

  // ------------------------------------------------- fraction divider
  rci_pkg::pipe_ctl_t dv1_ctl;
  logic [NUM1_W-1:0]  dv1_num [1];
  logic [30:0]        dv1_quo [1];
  div1_side_t         dv1_so;

  assign dv1_ctl    = '{en: pipe_en, vld: v10_q};
  assign dv1_num[0] = num10_q;

  rci_div_pipe #(
    .NUM_W  (NUM1_W),
    .DEN_W  (63),
    .QW     (31),
    .LANES  (1),
    .SIDE_W ($bits(div1_side_t))
  ) u_div_frac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dv1_ctl),
    .num_i  (dv1_num),
    .den_i  (den10_q),
    .side_i (side10_q),
    .vld_o  (dv1_vld),
    .quo_o  (dv1_quo),
    .side_o (dv1_so)
  );

  // ------------------------------------ stage 11: fraction times direction
  logic [30:0]        f11_d, f11_q;
  logic signed [63:0] pfx11_q, pfy11_q;
  logic signed [31:0] sx11_q, sy11_q;
  logic               miss11_q;

  assign f11_d = dv1_so.over ? rci_pkg::DP_MAX[30:0] : dv1_quo[0];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      f11_q    <= f11_d;
      pfx11_q  <= $signed({1'b0, f11_d}) * dv1_so.dx;
      pfy11_q  <= $signed({1'b0, f11_d}) * dv1_so.dy;
      sx11_q   <= dv1_so.sx;
      sy11_q   <= dv1_so.sy;
      miss11_q <= dv1_so.miss;
    end
  end

  // ---------------------------------- stage 12: hit point from the centre
  logic signed [31:0] hx12_q, hy12_q;
  logic [30:0]        f12_q;
  logic               miss12_q;
  localparam logic signed [71:0] HALF_F = 72'sd1 <<< (F - 1);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      hx12_q   <= sat_dp(72'(sx11_q) + ((72'(pfx11_q) + HALF_F) >>> F));
      hy12_q   <= sat_dp(72'(sy11_q) + ((72'(pfy11_q) + HALF_F) >>> F));
      f12_q    <= f11_q;
      miss12_q <= miss11_q;
    end
  end

  // ----------------------------------------- stage 13: squared magnitudes
  logic [30:0] mx13_d, my13_d;
  logic [31:0] nhx, nhy;
  logic [61:0] sqx13_q, sqy13_q;
  sq2_side_t   s13_q;

  always_comb begin
    nhx    = 32'(-hx12_q);
    nhy    = 32'(-hy12_q);
    mx13_d = hx12_q[31] ? nhx[30:0] : hx12_q[30:0];
    my13_d = hy12_q[31] ? nhy[30:0] : hy12_q[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sqx13_q    <= mx13_d * mx13_d;
      sqy13_q    <= my13_d * my13_d;
      s13_q.miss <= miss12_q;
      s13_q.f    <= f12_q;
      s13_q.mx   <= mx13_d;
      s13_q.my   <= my13_d;
      s13_q.negx <= hx12_q[31];
      s13_q.negy <= hy12_q[31];
    end
  end

  // ------------------------------------------------ stage 14: length^2
  logic [63:0] len2_14_q;
  sq2_side_t   s14_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      len2_14_q <= 64'(sqx13_q) + 64'(sqy13_q);
      s14_q     <= s13_q;
    end
  end

  // ---------------------------------------------- square root of length^2
  rci_pkg::pipe_ctl_t sq2_ctl;
  logic [31:0]        sq2_root;
  sq2_side_t          sq2_so;

  assign sq2_ctl = '{en: pipe_en, vld: v14_q};

  rci_isqrt_pipe #(
    .RAD_W  (64),
    .SIDE_W ($bits(sq2_side_t))
  ) u_sqrt_len (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq2_ctl),
    .rad_i  (len2_14_q),
    .side_i (s14_q),
    .vld_o  (sq2_vld),
    .root_o (sq2_root),
    .side_o (sq2_so)
  );

  // ------------------------------- stage 15: rounded normal numerators
  logic              lz15;
  logic [NUM2_W-1:0] numx15_q, numy15_q;
  logic [31:0]       den15_q;
  div2_side_t        s15_q;

  assign lz15 = (sq2_root == 32'd0);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      // A zero length is replaced by a divisor of one and the result dropped.
      den15_q    <= lz15 ? 32'd1 : sq2_root;
      numx15_q   <= lz15 ? '0 : (NUM2_W'(sq2_so.mx) << rci_pkg::ROT_FRAC_BITS)
                             + NUM2_W'(sq2_root >> 1);
      numy15_q   <= lz15 ? '0 : (NUM2_W'(sq2_so.my) << rci_pkg::ROT_FRAC_BITS)
                             + NUM2_W'(sq2_root >> 1);
      s15_q.miss <= sq2_so.miss;
      s15_q.lz   <= lz15;
      s15_q.f    <= sq2_so.f;
      s15_q.negx <= sq2_so.negx;
      s15_q.negy <= sq2_so.negy;
    end
  end

  // -------------------------------------------------- normal divider
  rci_pkg::pipe_ctl_t           dv2_ctl;
  logic [NUM2_W-1:0]            dv2_num [2];
  logic [rci_pkg::NORM_QW-1:0]  dv2_quo [2];
  div2_side_t                   dv2_so;

  assign dv2_ctl    = '{en: pipe_en, vld: v15_q};
  assign dv2_num[0] = numx15_q;
  assign dv2_num[1] = numy15_q;

  rci_div_pipe #(
    .NUM_W  (NUM2_W),
    .DEN_W  (32),
    .QW     (rci_pkg::NORM_QW),
    .LANES  (2),
    .SIDE_W ($bits(div2_side_t))
  ) u_div_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dv2_ctl),
    .num_i  (dv2_num),
    .den_i  (den15_q),
    .side_i (s15_q),
    .vld_o  (dv2_vld),
    .quo_o  (dv2_quo),
    .side_o (dv2_so)
  );

  // --------------------------------------------- result and output buffer
  result_t                            res_d;
  logic signed [rci_pkg::NORM_W-1:0]  qx, qy;

  always_comb begin
    qx         = $signed({1'b0, dv2_quo[0]});
    qy         = $signed({1'b0, dv2_quo[1]});
    res_d.hit  = !dv2_so.miss;
    res_d.frac = dv2_so.miss ? '0 : dv2_so.f;
    if (dv2_so.miss || dv2_so.lz) begin
      res_d.nx = '0;
      res_d.ny = '0;
    end else begin
      res_d.nx = dv2_so.negx ? -qx : qx;
      res_d.ny = dv2_so.negy ? -qy : qy;
    end
  end

  result_t fifo_q [2];
  logic    wptr_q, rptr_q;
  logic    push, pop;
  logic [1:0] cnt_d;

  assign push  = pipe_en && dv2_vld;
  assign pop   = out_valid_o && out_ready_i;
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= res_d;
    end
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign hit_o          = fifo_q[rptr_q].hit;
  assign hit_fraction_o = fifo_q[rptr_q].frac;
  assign normal_x_o     = fifo_q[rptr_q].nx;
  assign normal_y_o     = fifo_q[rptr_q].ny;

endmodule

`default_nettype wire
